// File: rtl/pfr_pkg.sv
// Shared types, constants and helpers for the page frame replacement block
`timescale 1ns / 1ps
package pfr_pkg;

    localparam int PROC_W   = 4;
    localparam int PAGE_W   = 5;
    localparam int IDX_W    = PROC_W + PAGE_W;
    localparam int FRAME_W  = 8;
    localparam int FRAMES   = 1 << FRAME_W;
    localparam int SLOTS    = 1 << IDX_W;
    localparam int AGE_W    = 9;
    localparam int STAMP_W  = 32;
    localparam int CNT_W    = 9;
    localparam int PERIOD_W = 16;

    localparam logic [1:0] ST_HIT     = 2'd0;
    localparam logic [1:0] ST_FREE    = 2'd1;
    localparam logic [1:0] ST_EVICT   = 2'd2;
    localparam logic [1:0] ST_RELEASE = 2'd3;

    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef struct packed {
        logic               used;
        logic [IDX_W-1:0]   owner;
        logic [AGE_W-1:0]   age;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
    } t_frame_ent;

    typedef struct packed {
        logic               used;
        logic [FRAME_W-1:0] frame;
    } t_map_ent;

    typedef struct packed {
        logic               free_found;
        logic [FRAME_W-1:0] free_idx;
        logic [FRAME_W-1:0] age_idx;
        logic [FRAME_W-1:0] stamp_idx;
    } t_scan_res;

    // reference byte on a hit: 0 -> 1, else OR in the bit above the top bit, cap 256
    function automatic logic [AGE_W-1:0] age_extend(input logic [AGE_W-1:0] a);
        logic [7:0] lo;
        logic [7:0] s;
        lo = a[7:0];
        s  = lo | (lo >> 1) | (lo >> 2) | (lo >> 3) | (lo >> 4)
                | (lo >> 5) | (lo >> 6) | (lo >> 7);
        if (a == '0) begin
            age_extend = AGE_W'(1);
        end else if (a >= AGE_W'(128)) begin
            age_extend = AGE_W'(256);
        end else begin
            age_extend = {1'b0, lo | (s + 8'd1)};
        end
    endfunction

endpackage

// File: rtl/page_frame_replacement_top.sv
// Page frame allocator with FIFO or aging-LRU replacement, sequenced over a frame RAM
// A hit reads the page map, then the frame; a fault runs one full frame scan, one
// frame per cycle, plus a victim read on an eviction; a release sweeps the frames,
// then does 32 map clears. An access that ends a shift period adds an ageing sweep.
// One transaction at a time. Reset (synchronous, active low) starts a clearing
// pass over the page map and frame table; no request is accepted until it ends.
`timescale 1ns / 1ps
module page_frame_replacement_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // proc_id[3:0], page_num[8:4], is_write[9]
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // frame[7:0], victim_valid[8], victim_proc[12:9],
                                   // victim_page[17:13], victim_dirty[18], frames_freed[27:19]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import pfr_pkg::*;

    typedef enum logic [10:0] {
        S_CLR    = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_MAPRD  = 11'b00000000100,
        S_HITRD  = 11'b00000001000,
        S_SCAN   = 11'b00000010000,
        S_PICK   = 11'b00000100000,
        S_VICRD  = 11'b00001000000,
        S_LOAD   = 11'b00010000000,
        S_REL    = 11'b00100000000,
        S_RELMAP = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_aging;

    logic                r_policy;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_acc;
    logic [STAMP_W-1:0]  r_stamp;
    logic [CNT_W-1:0]    r_cnt;

    logic               r_rt;
    logic [PROC_W-1:0]  r_proc;
    logic [PAGE_W-1:0]  r_page;
    logic               r_wr;
    logic [FRAME_W-1:0] r_frame;
    logic [1:0]         r_status;
    logic               r_vv;
    logic [PROC_W-1:0]  r_vproc;
    logic [PAGE_W-1:0]  r_vpage;
    logic               r_vdirty;
    logic [CNT_W-1:0]   r_freed;

    logic        r_m_tvalid;
    logic [31:0] r_m_tdata;
    logic [1:0]  r_m_tuser;

    logic               map_we;
    logic [IDX_W-1:0]   map_waddr;
    t_map_ent           map_wdata;
    logic [IDX_W-1:0]   map_raddr;
    t_map_ent           map_rdata;
    logic               frm_we;
    logic [FRAME_W-1:0] frm_waddr;
    t_frame_ent         frm_wdata;
    logic [FRAME_W-1:0] frm_raddr;
    t_frame_ent         frm_rdata;

    logic               scan_start;
    logic               scan_en;
    t_scan_res          scan_res;
    logic [FRAME_W-1:0] prev_idx;
    logic               cnt_end;
    logic               out_free;
    logic               rel_match;
    logic [FRAME_W-1:0] victim_idx;
    logic [PERIOD_W-1:0] acc_inc;

    assign prev_idx   = FRAME_W'(r_cnt - CNT_W'(1));
    assign cnt_end    = (r_cnt == CNT_W'(FRAMES));
    assign out_free   = !r_m_tvalid || m_tready;
    assign rel_match  = (r_cnt != '0) && frm_rdata.used
                        && (frm_rdata.owner[IDX_W-1:PAGE_W] == r_proc);
    assign victim_idx = r_policy ? scan_res.stamp_idx : scan_res.age_idx;
    assign acc_inc    = r_acc + PERIOD_W'(1);
    assign s_tready   = (r_state == S_IDLE) && !r_aging;

    pfr_ram #(.AW(IDX_W), .DW($bits(t_map_ent))) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    pfr_ram #(.AW(FRAME_W), .DW($bits(t_frame_ent))) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (frm_waddr),
        .i_wdata (frm_wdata),
        .i_raddr (frm_raddr),
        .o_rdata (frm_rdata)
    );

    assign scan_start = (r_state == S_MAPRD);
    assign scan_en    = (r_state == S_SCAN) && (r_cnt != '0);

    pfr_scan u_scan (
        .i_clk   (i_clk),
        .i_start (scan_start),
        .i_en    (scan_en),
        .i_idx   (prev_idx),
        .i_ent   (frm_rdata),
        .o_res   (scan_res)
    );

    // memory port steering
    always_comb begin
        map_we    = 1'b0;
        map_waddr = {r_proc, r_page};
        map_wdata = '0;
        map_raddr = {s_tdata[3:0], s_tdata[8:4]};
        frm_we    = 1'b0;
        frm_waddr = prev_idx;
        frm_wdata = '0;
        frm_raddr = r_cnt[FRAME_W-1:0];
        unique case (r_state)
            S_CLR: begin
                map_we    = 1'b1;
                map_waddr = r_cnt;
                frm_we    = 1'b1;
                frm_waddr = r_cnt[FRAME_W-1:0];
            end
            S_IDLE: begin
                if (r_aging && r_cnt != '0) begin
                    frm_we        = 1'b1;
                    frm_wdata     = frm_rdata;
                    frm_wdata.age = frm_rdata.age >> 1;
                end
            end
            S_MAPRD: begin
                frm_raddr = map_rdata.frame;
            end
            S_HITRD: begin
                frm_we          = 1'b1;
                frm_waddr       = r_frame;
                frm_wdata       = frm_rdata;
                frm_wdata.age   = age_extend(frm_rdata.age);
                frm_wdata.dirty = frm_rdata.dirty | r_wr;
            end
            S_SCAN: begin
            end
            S_PICK: begin
                frm_raddr = victim_idx;
            end
            S_VICRD: begin
                map_we    = 1'b1;
                map_waddr = frm_rdata.owner;
            end
            S_LOAD: begin
                map_we          = 1'b1;
                map_wdata.used  = 1'b1;
                map_wdata.frame = r_frame;
                frm_we          = 1'b1;
                frm_waddr       = r_frame;
                frm_wdata.used  = 1'b1;
                frm_wdata.owner = {r_proc, r_page};
                frm_wdata.age   = AGE_W'(1);
                frm_wdata.dirty = r_wr;
                frm_wdata.stamp = r_stamp;
            end
            S_REL: begin
                frm_we = rel_match;
            end
            S_RELMAP: begin
                map_we    = 1'b1;
                map_waddr = {r_proc, r_cnt[PAGE_W-1:0]};
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:    if (r_cnt == CNT_W'(SLOTS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (!r_aging && s_tvalid) begin
                    n_state = s_tuser[0] ? S_REL : S_MAPRD;
                end
            end
            S_MAPRD:  n_state = map_rdata.used ? S_HITRD : S_SCAN;
            S_HITRD:  n_state = S_DONE;
            S_SCAN:   if (cnt_end) n_state = S_PICK;
            S_PICK:   n_state = scan_res.free_found ? S_LOAD : S_VICRD;
            S_VICRD:  n_state = S_LOAD;
            S_LOAD:   n_state = S_DONE;
            S_REL:    if (cnt_end) n_state = S_RELMAP;
            S_RELMAP: if (r_cnt[PAGE_W-1:0] == '1) n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_aging    <= 1'b0;
            r_cnt      <= '0;
            r_policy   <= 1'b1;
            r_period   <= PERIOD_W'(200);
            r_acc      <= '0;
            r_stamp    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_POLICY: r_policy <= i_cfg_wdata[0];
                    REG_PERIOD: r_period <= i_cfg_wdata;
                    default:    r_policy <= r_policy;
                endcase
            end
            if (r_state == S_DONE && out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_tvalid && m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_cnt <= (r_cnt == CNT_W'(SLOTS - 1)) ? '0 : r_cnt + CNT_W'(1);
                end
                S_IDLE: begin
                    if (r_aging) begin
                        // halve every reference byte, read one ahead of the write
                        if (cnt_end) begin
                            r_aging <= 1'b0;
                            r_cnt   <= '0;
                        end else begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end
                    end else if (s_tvalid) begin
                        r_rt     <= s_tuser[0];
                        r_proc   <= s_tdata[3:0];
                        r_page   <= s_tdata[8:4];
                        r_wr     <= s_tdata[9];
                        r_cnt    <= '0;
                        r_freed  <= '0;
                        r_vv     <= 1'b0;
                        r_vproc  <= '0;
                        r_vpage  <= '0;
                        r_vdirty <= 1'b0;
                        r_frame  <= '0;
                        r_status <= s_tuser[0] ? ST_RELEASE : ST_HIT;
                    end
                end
                S_MAPRD: begin
                    r_frame <= map_rdata.frame;
                    r_cnt   <= '0;
                end
                S_HITRD: begin
                end
                S_SCAN: begin
                    r_cnt <= cnt_end ? '0 : r_cnt + CNT_W'(1);
                end
                S_PICK: begin
                    if (scan_res.free_found) begin
                        r_frame  <= scan_res.free_idx;
                        r_status <= ST_FREE;
                    end else begin
                        r_frame  <= victim_idx;
                        r_status <= ST_EVICT;
                    end
                end
                S_VICRD: begin
                    r_vv     <= 1'b1;
                    r_vproc  <= frm_rdata.owner[IDX_W-1:PAGE_W];
                    r_vpage  <= frm_rdata.owner[PAGE_W-1:0];
                    r_vdirty <= frm_rdata.dirty;
                end
                S_LOAD: begin
                    r_stamp <= r_stamp + STAMP_W'(1);
                end
                S_REL: begin
                    if (rel_match) begin
                        r_freed <= r_freed + CNT_W'(1);
                    end
                    r_cnt <= cnt_end ? '0 : r_cnt + CNT_W'(1);
                end
                S_RELMAP: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                S_DONE: begin
                    if (out_free) begin
                        r_m_tuser  <= r_status;
                        r_m_tdata  <= {4'd0, r_freed, r_vdirty, r_vpage, r_vproc,
                                       r_vv, r_frame};
                        r_cnt      <= '0;
                        if (!r_rt) begin
                            if (acc_inc == r_period) begin
                                r_acc   <= '0;
                                r_aging <= 1'b1;
                            end else begin
                                r_acc <= acc_inc;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

endmodule

// File: rtl/pfr_ram.sv
// Simple dual-port RAM, one write and one registered read per cycle
`timescale 1ns / 1ps
module pfr_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/pfr_scan.sv
// Frame scan unit: first free frame, least reference byte, oldest load
`timescale 1ns / 1ps
module pfr_scan (
    input  logic                   i_clk,
    input  logic                   i_start,
    input  logic                   i_en,
    input  logic [pfr_pkg::FRAME_W-1:0] i_idx,
    input  pfr_pkg::t_frame_ent    i_ent,
    output pfr_pkg::t_scan_res     o_res
);
    import pfr_pkg::*;

    logic               r_first;
    logic               r_free_found;
    logic [FRAME_W-1:0] r_free_idx;
    logic [FRAME_W-1:0] r_age_idx;
    logic [FRAME_W-1:0] r_stamp_idx;
    logic [AGE_W-1:0]   r_best_age;
    logic [STAMP_W-1:0] r_best_stamp;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_first      <= 1'b1;
            r_free_found <= 1'b0;
        end else if (i_en) begin
            r_first <= 1'b0;
            if (!r_free_found && !i_ent.used) begin
                r_free_found <= 1'b1;
                r_free_idx   <= i_idx;
            end
            // strict compare keeps the lowest index on a tie
            if (r_first || i_ent.age < r_best_age) begin
                r_best_age <= i_ent.age;
                r_age_idx  <= i_idx;
            end
            if (r_first || i_ent.stamp < r_best_stamp) begin
                r_best_stamp <= i_ent.stamp;
                r_stamp_idx  <= i_idx;
            end
        end
    end

    assign o_res.free_found = r_free_found;
    assign o_res.free_idx   = r_free_idx;
    assign o_res.age_idx    = r_age_idx;
    assign o_res.stamp_idx  = r_stamp_idx;

endmodule
